### src/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Types, codes and reset constants of the countdown timer table.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int TIMER_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF   = 48;

    localparam logic [31:0] MIN_DURATION_RST = 32'd1000;
    localparam logic [31:0] MAX_DURATION_RST = 32'd86400000;
    localparam logic [31:0] U32_MAX          = 32'hFFFF_FFFF;

    localparam logic [0:0] CFG_MIN_DURATION = 1'd0;
    localparam logic [0:0] CFG_MAX_DURATION = 1'd1;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_CANCEL  = 3'd4,
        OP_RESTART = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        RC_OK       = 3'd0,
        RC_INVALID  = 3'd1,
        RC_ABSENT   = 3'd2,
        RC_CONFLICT = 3'd3,
        RC_CAPACITY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PAUSED  = 2'd2,
        ST_EXPIRED = 2'd3
    } slot_state_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_SCAN_RD,
        FSM_SCAN,
        FSM_SWEEP_RD,
        FSM_SWEEP,
        FSM_FIND_RD,
        FSM_FIND,
        FSM_APPLY,
        FSM_VIEW_RD,
        FSM_VIEW,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [TIME_BITS_DEF-1:0] now_ms;
        logic [31:0]              duration_in;
        logic [31:0]              target_id;
        logic [31:0]              expected_rev;
    } cmd_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [5:0]               expired_count;
        logic [31:0]              view_id;
        logic [31:0]              view_revision;
        logic [31:0]              view_duration;
        logic [31:0]              view_occurrence;
        logic [TIME_BITS_DEF-1:0] view_deadline;
        logic [31:0]              view_remaining;
        logic [1:0]               view_state;
        logic                     view_alert;
        logic [31:0]              table_revision;
    } rsp_t;

    // slot entry held in memory, deadline stored at full 64-bit max width
    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] id;
        logic [31:0] revision;
        logic [31:0] duration;
        logic [31:0] occurrence;
        logic [63:0] deadline;
        logic [31:0] paused_left;
        logic        alert;
    } slot_t;

endpackage

### src/countdown_timer_table.sv
// Tick scans and sweeps every slot; pause, cancel and restart sweep and then search the table;
// create and resume only search it. Cancel and a change refused after the search skip the view
// read, and a command rejected at once goes straight to the result.
// One command at a time: input stalls until the cycle after the result transfer.
// After reset the slot valid bits clear at once so unused slots read as zero;
// registers reset to 1000 and 86400000; revision, id and occurrence reset to one.
// ----------------------------------------------------------------------------
// countdown_timer_table
// Table of countdown timers updated by commands through a one-port slot memory.
// ----------------------------------------------------------------------------
module countdown_timer_table #(
    parameter int TIMER_SLOTS = cdt_pkg::TIMER_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  cdt_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output cdt_pkg::rsp_t out_data
);

    localparam int TIME_BITS = cdt_pkg::TIME_BITS_DEF;
    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [63:0] TIME_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIME_BITS);
    localparam logic [SW-1:0] LAST = SW'(TIMER_SLOTS - 1);

    cdt_pkg::slot_t mem [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] vld_reg;
    cdt_pkg::slot_t rd_q;
    cdt_pkg::slot_t rd;
    logic [SW-1:0] addr;
    logic          we;
    cdt_pkg::slot_t wdata;

    cdt_pkg::fsm_t state_reg, state_next;
    cdt_pkg::cmd_t cmd_reg;
    cdt_pkg::rsp_t rsp_reg, rsp_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [CW-1:0] due_reg, due_next;
    logic          blk_reg, blk_next;
    logic          hit_reg, hit_next;
    logic [SW-1:0] hidx_reg, hidx_next;
    logic          free_reg, free_next;
    logic [SW-1:0] fidx_reg, fidx_next;
    logic [31:0]   grev_reg, grev_next;
    logic [31:0]   nid_reg, nid_next;
    logic [31:0]   nocc_reg, nocc_next;
    logic [31:0]   min_reg, max_reg;

    logic [63:0] now;
    logic        due_now;
    logic [63:0] left64;
    logic [31:0] left;
    logic [63:0] addv;
    logic [63:0] sum;
    logic        ovf;
    logic        tick_op, sweep_op, chg_op;

    assign now = 64'(cmd_reg.now_ms) & TIME_MASK;
    assign rd  = rd_q;
    assign tick_op  = cmd_reg.opcode == cdt_pkg::OP_TICK;
    assign chg_op   = cmd_reg.opcode inside {cdt_pkg::OP_PAUSE, cdt_pkg::OP_RESUME,
                                             cdt_pkg::OP_CANCEL, cdt_pkg::OP_RESTART};
    assign sweep_op = tick_op || (chg_op && cmd_reg.opcode != cdt_pkg::OP_RESUME);
    assign due_now  = rd.state == cdt_pkg::ST_RUNNING && now >= rd.deadline;

    always_comb
    begin
        left64 = rd.deadline - now;
        if (rd.state == cdt_pkg::ST_PAUSED)
            left = rd.paused_left;
        else if (rd.state != cdt_pkg::ST_RUNNING || now >= rd.deadline)
            left = '0;
        else if (left64[63:32] != '0)
            left = cdt_pkg::U32_MAX;
        else
            left = left64[31:0];
    end

    always_comb
    begin
        case (cmd_reg.opcode)
            cdt_pkg::OP_CREATE:  addv = {32'd0, cmd_reg.duration_in};
            cdt_pkg::OP_RESUME:  addv = {32'd0, rd.paused_left};
            default:             addv = {32'd0, rd.duration};
        endcase
        sum = now + addv;
        ovf = addv > (TIME_MASK - now);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rd_q <= vld_reg[addr] ? mem[addr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= cdt_pkg::MIN_DURATION_RST;
            max_reg <= cdt_pkg::MAX_DURATION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cdt_pkg::CFG_MIN_DURATION: min_reg <= cfg_data;
                cdt_pkg::CFG_MAX_DURATION: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdt_pkg::FSM_IDLE;
            grev_reg  <= 32'd1;
            nid_reg   <= 32'd1;
            nocc_reg  <= 32'd1;
            idx_reg   <= '0;
            due_reg   <= '0;
            blk_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            hidx_reg  <= '0;
            free_reg  <= 1'b0;
            fidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grev_reg  <= grev_next;
            nid_reg   <= nid_next;
            nocc_reg  <= nocc_next;
            idx_reg   <= idx_next;
            due_reg   <= due_next;
            blk_reg   <= blk_next;
            hit_reg   <= hit_next;
            hidx_reg  <= hidx_next;
            free_reg  <= free_next;
            fidx_reg  <= fidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cdt_pkg::FSM_IDLE && in_valid)
            cmd_reg <= in_data;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        idx_next   = idx_reg;
        due_next   = due_reg;
        blk_next   = blk_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        free_next  = free_reg;
        fidx_next  = fidx_reg;
        grev_next  = grev_reg;
        nid_next   = nid_reg;
        nocc_next  = nocc_reg;
        addr       = idx_reg;
        we         = 1'b0;
        wdata      = rd;
        in_stall   = state_reg != cdt_pkg::FSM_IDLE;
        out_valid  = state_reg == cdt_pkg::FSM_OUT;
        out_data   = rsp_reg;
        case (state_reg)
            cdt_pkg::FSM_IDLE:
            begin
                idx_next = '0;
                due_next = '0;
                blk_next = 1'b0;
                hit_next = 1'b0;
                free_next = 1'b0;
                if (in_valid)
                    state_next = cdt_pkg::FSM_SCAN_RD;
            end
            cdt_pkg::FSM_SCAN_RD:
            begin
                rsp_next = '0;
                rsp_next.table_revision = grev_reg;
                if (cmd_reg.opcode > cdt_pkg::OP_RESTART
                    || (chg_op && cmd_reg.expected_rev == '0))
                begin
                    rsp_next.status = cdt_pkg::RC_INVALID;
                    state_next = cdt_pkg::FSM_OUT;
                end
                else if (cmd_reg.opcode == cdt_pkg::OP_CREATE
                         && (cmd_reg.duration_in < min_reg
                             || cmd_reg.duration_in > max_reg))
                begin
                    rsp_next.status = cdt_pkg::RC_INVALID;
                    state_next = cdt_pkg::FSM_OUT;
                end
                else if (sweep_op)
                    state_next = cdt_pkg::FSM_SCAN;
                else
                    state_next = cdt_pkg::FSM_FIND_RD;
            end
            cdt_pkg::FSM_SCAN:
            begin
                if (due_now)
                begin
                    due_next = due_reg + CW'(1);
                    if (rd.revision == cdt_pkg::U32_MAX)
                        blk_next = 1'b1;
                end
                if (idx_reg == LAST)
                begin
                    if ({1'b0, grev_reg} + {{(33 - CW){1'b0}}, due_next}
                        > {1'b0, cdt_pkg::U32_MAX})
                        blk_next = 1'b1;
                    idx_next = '0;
                    due_next = '0;
                    state_next = cdt_pkg::FSM_SWEEP_RD;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                    state_next = cdt_pkg::FSM_SCAN;
                    addr = idx_reg + SW'(1);
                end
            end
            cdt_pkg::FSM_SWEEP_RD:
            begin
                state_next = cdt_pkg::FSM_SWEEP;
            end
            cdt_pkg::FSM_SWEEP:
            begin
                if (!blk_reg && due_now && grev_reg != cdt_pkg::U32_MAX
                    && rd.revision != cdt_pkg::U32_MAX)
                begin
                    we = 1'b1;
                    wdata.state = cdt_pkg::ST_EXPIRED;
                    wdata.paused_left = '0;
                    wdata.alert = 1'b1;
                    wdata.revision = rd.revision + 32'd1;
                    grev_next = grev_reg + 32'd1;
                    due_next = due_reg + CW'(1);
                end
                if (idx_reg == LAST)
                begin
                    idx_next = '0;
                    state_next = cdt_pkg::FSM_FIND_RD;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                    state_next = cdt_pkg::FSM_SWEEP_RD;
                end
            end
            cdt_pkg::FSM_FIND_RD:
            begin
                state_next = cdt_pkg::FSM_FIND;
                if (tick_op)
                begin
                    rsp_next.expired_count = 6'(due_reg);
                    rsp_next.table_revision = grev_reg;
                    state_next = cdt_pkg::FSM_OUT;
                end
            end
            cdt_pkg::FSM_FIND:
            begin
                if (!hit_reg && cmd_reg.target_id != '0 && rd.state != cdt_pkg::ST_UNUSED
                    && rd.id == cmd_reg.target_id)
                begin
                    hit_next = 1'b1;
                    hidx_next = idx_reg;
                end
                if (!free_reg && rd.state == cdt_pkg::ST_UNUSED)
                begin
                    free_next = 1'b1;
                    fidx_next = idx_reg;
                end
                if (idx_reg == LAST)
                    state_next = cdt_pkg::FSM_APPLY;
                else
                begin
                    idx_next = idx_reg + SW'(1);
                    state_next = cdt_pkg::FSM_FIND_RD;
                end
                addr = (cmd_reg.opcode == cdt_pkg::OP_CREATE) ? fidx_next : hidx_next;
            end
            cdt_pkg::FSM_APPLY:
            begin
                addr = (cmd_reg.opcode == cdt_pkg::OP_CREATE) ? fidx_reg : hidx_reg;
                state_next = cdt_pkg::FSM_VIEW_RD;
                if (cmd_reg.opcode == cdt_pkg::OP_CREATE)
                begin
                    if (grev_reg == cdt_pkg::U32_MAX || nid_reg == '0 || nocc_reg == '0
                        || ovf || !free_reg)
                    begin
                        rsp_next.status = cdt_pkg::RC_CAPACITY;
                        state_next = cdt_pkg::FSM_OUT;
                    end
                    else
                    begin
                        we = 1'b1;
                        wdata.id = nid_reg;
                        wdata.revision = 32'd1;
                        wdata.duration = cmd_reg.duration_in;
                        wdata.occurrence = nocc_reg;
                        wdata.deadline = sum;
                        wdata.paused_left = '0;
                        wdata.state = cdt_pkg::ST_RUNNING;
                        wdata.alert = 1'b0;
                        nid_next = nid_reg + 32'd1;
                        nocc_next = nocc_reg + 32'd1;
                        grev_next = grev_reg + 32'd1;
                    end
                end
                else if (!hit_reg)
                begin
                    rsp_next.status = cdt_pkg::RC_ABSENT;
                    state_next = cdt_pkg::FSM_OUT;
                end
                else if (rd.revision != cmd_reg.expected_rev
                    || (cmd_reg.opcode == cdt_pkg::OP_PAUSE && rd.state != cdt_pkg::ST_RUNNING)
                    || (cmd_reg.opcode == cdt_pkg::OP_RESUME && rd.state != cdt_pkg::ST_PAUSED)
                    || (cmd_reg.opcode == cdt_pkg::OP_CANCEL && rd.state == cdt_pkg::ST_EXPIRED)
                    || (cmd_reg.opcode == cdt_pkg::OP_RESTART
                        && rd.state != cdt_pkg::ST_EXPIRED))
                begin
                    rsp_next.status = cdt_pkg::RC_CONFLICT;
                    state_next = cdt_pkg::FSM_OUT;
                end
                else if (grev_reg == cdt_pkg::U32_MAX || rd.revision == cdt_pkg::U32_MAX
                    || (cmd_reg.opcode == cdt_pkg::OP_RESUME && ovf)
                    || (cmd_reg.opcode == cdt_pkg::OP_RESTART && (nocc_reg == '0 || ovf)))
                begin
                    rsp_next.status = cdt_pkg::RC_CAPACITY;
                    state_next = cdt_pkg::FSM_OUT;
                end
                else
                begin
                    we = 1'b1;
                    grev_next = grev_reg + 32'd1;
                    wdata.revision = rd.revision + 32'd1;
                    case (cmd_reg.opcode)
                        cdt_pkg::OP_PAUSE:
                        begin
                            wdata.paused_left = left;
                            wdata.deadline = '0;
                            wdata.state = cdt_pkg::ST_PAUSED;
                        end
                        cdt_pkg::OP_RESUME:
                        begin
                            wdata.deadline = sum;
                            wdata.paused_left = '0;
                            wdata.state = cdt_pkg::ST_RUNNING;
                        end
                        cdt_pkg::OP_CANCEL:
                        begin
                            wdata = '0;
                            state_next = cdt_pkg::FSM_OUT;
                        end
                        default:
                        begin
                            wdata.occurrence = nocc_reg;
                            nocc_next = nocc_reg + 32'd1;
                            wdata.deadline = sum;
                            wdata.paused_left = '0;
                            wdata.state = cdt_pkg::ST_RUNNING;
                            wdata.alert = 1'b0;
                        end
                    endcase
                end
                rsp_next.table_revision = grev_next;
            end
            cdt_pkg::FSM_VIEW_RD:
            begin
                addr = (cmd_reg.opcode == cdt_pkg::OP_CREATE) ? fidx_reg : hidx_reg;
                state_next = cdt_pkg::FSM_VIEW;
            end
            cdt_pkg::FSM_VIEW:
            begin
                addr = (cmd_reg.opcode == cdt_pkg::OP_CREATE) ? fidx_reg : hidx_reg;
                rsp_next.view_id = rd.id;
                rsp_next.view_revision = rd.revision;
                rsp_next.view_duration = rd.duration;
                rsp_next.view_occurrence = rd.occurrence;
                rsp_next.view_deadline = rd.deadline[TIME_BITS-1:0];
                rsp_next.view_remaining = left;
                rsp_next.view_state = rd.state;
                rsp_next.view_alert = rd.alert;
                state_next = cdt_pkg::FSM_OUT;
            end
            cdt_pkg::FSM_OUT:
            begin
                if (!out_stall)
                    state_next = cdt_pkg::FSM_IDLE;
            end
            default:
                state_next = cdt_pkg::FSM_IDLE;
        endcase
    end

endmodule

### src/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks of the countdown timer table.
// ----------------------------------------------------------------------------
module cdt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input cdt_pkg::rsp_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= cdt_pkg::RC_CAPACITY)
        else $error("bad status code");

    a_noview: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != cdt_pkg::RC_OK |-> out_data.view_id == '0
        && out_data.expired_count == '0)
        else $error("view on failed transfer");

endmodule

bind countdown_timer_table cdt_checker u_cdt_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the countdown timer table with a directed table of commands and
// random command streams, predicts every response and compares each one as a whole.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS = 8;
    localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;
    localparam int NUM_RANDOM = 1600;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        cdt_pkg::cmd_t cmd;
        logic check;
        cdt_pkg::rsp_t rsp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = cdt_pkg::CFG_MIN_DURATION;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    cdt_pkg::cmd_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    cdt_pkg::rsp_t out_data;

    cdt_pkg::slot_state_t m_state[SLOTS];
    logic [31:0] m_id[SLOTS];
    logic [31:0] m_rev[SLOTS];
    logic [31:0] m_dur[SLOTS];
    logic [31:0] m_occ[SLOTS];
    logic [47:0] m_deadline[SLOTS];
    logic [31:0] m_left[SLOTS];
    logic m_alert[SLOTS];
    logic [31:0] m_table_rev, m_next_id, m_next_occ, m_min_dur, m_max_dur;

    cdt_pkg::rsp_t pending_rsp[$];
    row_t directed[$];
    int errors = 0;
    int idle_count = 0;
    logic stall_free = 1'b0;
    logic hold_off = 1'b0;
    logic [47:0] clock_ms = 48'd5000;

    countdown_timer_table dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] time_left(int s, logic [47:0] now);
        logic [47:0] d;
        if (m_state[s] == cdt_pkg::ST_PAUSED) return m_left[s];
        if (m_state[s] != cdt_pkg::ST_RUNNING || now >= m_deadline[s]) return 32'd0;
        d = m_deadline[s] - now;
        return (d > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    endfunction

    function automatic logic overflows(logic [47:0] now, logic [47:0] add);
        return add > (TMASK - now);
    endfunction

    function automatic int expire_due(logic [47:0] now);
        int due;
        due = 0;
        for (int i = 0; i < SLOTS; i++)
            if (m_state[i] == cdt_pkg::ST_RUNNING && now >= m_deadline[i])
            begin
                if (m_rev[i] == cdt_pkg::U32_MAX) return 0;
                due++;
            end
        if ({32'd0, m_table_rev} + due > {32'd0, cdt_pkg::U32_MAX}) return 0;
        due = 0;
        for (int i = 0; i < SLOTS; i++)
            if (m_state[i] == cdt_pkg::ST_RUNNING && now >= m_deadline[i]
                && m_table_rev != cdt_pkg::U32_MAX && m_rev[i] != cdt_pkg::U32_MAX)
            begin
                m_state[i] = cdt_pkg::ST_EXPIRED;
                m_left[i] = '0;
                m_alert[i] = 1'b1;
                m_table_rev++;
                m_rev[i]++;
                due++;
            end
        return due;
    endfunction

    function automatic void clear_entry(int s);
        m_state[s] = cdt_pkg::ST_UNUSED;
        m_id[s] = '0; m_rev[s] = '0; m_dur[s] = '0; m_occ[s] = '0;
        m_deadline[s] = '0; m_left[s] = '0; m_alert[s] = 1'b0;
    endfunction

    function automatic void show_entry(int s, logic [47:0] now, ref cdt_pkg::rsp_t r);
        r.view_id = m_id[s];
        r.view_revision = m_rev[s];
        r.view_duration = m_dur[s];
        r.view_occurrence = m_occ[s];
        r.view_deadline = m_deadline[s];
        r.view_remaining = time_left(s, now);
        r.view_state = m_state[s];
        r.view_alert = m_alert[s];
    endfunction

    function automatic cdt_pkg::rsp_t timer_response(cdt_pkg::cmd_t c);
        cdt_pkg::rsp_t r;
        int s;
        logic [2:0] op;
        r = '0;
        s = -1;
        op = c.opcode;
        if (op == cdt_pkg::OP_TICK)
        begin
            r.expired_count = 6'(expire_due(c.now_ms));
        end
        else if (op == cdt_pkg::OP_CREATE)
        begin
            if (c.duration_in < m_min_dur || c.duration_in > m_max_dur)
                r.status = cdt_pkg::RC_INVALID;
            else if (m_table_rev == cdt_pkg::U32_MAX || m_next_id == 0 || m_next_occ == 0
                     || overflows(c.now_ms, {16'd0, c.duration_in}))
                r.status = cdt_pkg::RC_CAPACITY;
            else
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (m_state[i] == cdt_pkg::ST_UNUSED) s = i;
                if (s < 0) r.status = cdt_pkg::RC_CAPACITY;
                else
                begin
                    m_id[s] = m_next_id;
                    m_rev[s] = 32'd1;
                    m_dur[s] = c.duration_in;
                    m_occ[s] = m_next_occ;
                    m_deadline[s] = c.now_ms + c.duration_in;
                    m_left[s] = '0;
                    m_state[s] = cdt_pkg::ST_RUNNING;
                    m_alert[s] = 1'b0;
                    m_next_id = m_next_id + 1;
                    m_next_occ = m_next_occ + 1;
                    m_table_rev++;
                    show_entry(s, c.now_ms, r);
                end
            end
        end
        else if (op >= cdt_pkg::OP_PAUSE && op <= cdt_pkg::OP_RESTART)
        begin
            if (c.expected_rev == 0) r.status = cdt_pkg::RC_INVALID;
            else
            begin
                if (op != cdt_pkg::OP_RESUME) void'(expire_due(c.now_ms));
                if (c.target_id != 0)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (m_state[i] != cdt_pkg::ST_UNUSED && m_id[i] == c.target_id) s = i;
                if (s < 0) r.status = cdt_pkg::RC_ABSENT;
                else if (m_rev[s] != c.expected_rev
                         || (op == cdt_pkg::OP_PAUSE && m_state[s] != cdt_pkg::ST_RUNNING)
                         || (op == cdt_pkg::OP_RESUME && m_state[s] != cdt_pkg::ST_PAUSED)
                         || (op == cdt_pkg::OP_CANCEL && m_state[s] == cdt_pkg::ST_EXPIRED)
                         || (op == cdt_pkg::OP_RESTART && m_state[s] != cdt_pkg::ST_EXPIRED))
                    r.status = cdt_pkg::RC_CONFLICT;
                else if (m_table_rev == cdt_pkg::U32_MAX || m_rev[s] == cdt_pkg::U32_MAX
                         || (op == cdt_pkg::OP_RESUME
                             && overflows(c.now_ms, {16'd0, m_left[s]}))
                         || (op == cdt_pkg::OP_RESTART && (m_next_occ == 0
                             || overflows(c.now_ms, {16'd0, m_dur[s]}))))
                    r.status = cdt_pkg::RC_CAPACITY;
                else if (op == cdt_pkg::OP_CANCEL)
                begin
                    m_table_rev++;
                    clear_entry(s);
                end
                else
                begin
                    if (op == cdt_pkg::OP_PAUSE)
                    begin
                        m_left[s] = time_left(s, c.now_ms);
                        m_deadline[s] = '0;
                        m_state[s] = cdt_pkg::ST_PAUSED;
                    end
                    else if (op == cdt_pkg::OP_RESUME)
                    begin
                        m_deadline[s] = c.now_ms + m_left[s];
                        m_left[s] = '0;
                        m_state[s] = cdt_pkg::ST_RUNNING;
                    end
                    else
                    begin
                        m_occ[s] = m_next_occ;
                        m_next_occ = m_next_occ + 1;
                        m_deadline[s] = c.now_ms + m_dur[s];
                        m_left[s] = '0;
                        m_state[s] = cdt_pkg::ST_RUNNING;
                        m_alert[s] = 1'b0;
                    end
                    m_table_rev++;
                    m_rev[s]++;
                    show_entry(s, c.now_ms, r);
                end
            end
        end
        else
        begin
            r.status = cdt_pkg::RC_INVALID;
        end
        r.table_revision = m_table_rev;
        return r;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == cdt_pkg::CFG_MIN_DURATION) m_min_dur = val;
        else m_max_dur = val;
    endtask

    task automatic send_cmd(cdt_pkg::cmd_t c, logic check, cdt_pkg::rsp_t fixed);
        cdt_pkg::rsp_t r;
        if (!stall_free && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 15) @(posedge clk);
        end
        r = timer_response(c);
        if (check && r !== fixed)
        begin
            errors++;
            $display("%0t directed row expected %h, predicted %h", $time, fixed, r);
        end
        pending_rsp.push_back(r);
        in_valid <= 1'b1;
        in_data <= c;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic cdt_pkg::cmd_t mk(cdt_pkg::opcode_t op, logic [47:0] now,
                                         logic [31:0] dur, logic [31:0] id,
                                         logic [31:0] rev);
        cdt_pkg::cmd_t c;
        c.opcode = op; c.now_ms = now; c.duration_in = dur;
        c.target_id = id; c.expected_rev = rev;
        return c;
    endfunction

    function automatic void add_row(cdt_pkg::cmd_t c, logic chk, cdt_pkg::rsp_t r);
        row_t w;
        w.cmd = c; w.check = chk; w.rsp = r;
        directed.push_back(w);
    endfunction

    function automatic cdt_pkg::cmd_t random_cmd();
        cdt_pkg::cmd_t c;
        int s;
        int k;
        k = $urandom_range(99);
        s = $urandom_range(SLOTS - 1);
        c = '0;
        clock_ms = clock_ms + $urandom_range(3000);
        c.now_ms = clock_ms;
        c.target_id = m_id[s];
        c.expected_rev = m_rev[s];
        c.duration_in = $urandom_range(m_max_dur > 20000 ? 20000 : m_max_dur,
                                       m_min_dur > 20000 ? 20000 : m_min_dur);
        if (k < 25) c.opcode = cdt_pkg::OP_CREATE;
        else if (k < 40) c.opcode = cdt_pkg::OP_TICK;
        else if (k < 52) c.opcode = cdt_pkg::OP_PAUSE;
        else if (k < 64) c.opcode = cdt_pkg::OP_RESUME;
        else if (k < 74) c.opcode = cdt_pkg::OP_CANCEL;
        else if (k < 88) c.opcode = cdt_pkg::OP_RESTART;
        else
        begin
            c.opcode = 3'($urandom_range(7));
            c.now_ms = 48'({$urandom, $urandom});
            c.duration_in = $urandom;
            c.target_id = ($urandom_range(1)) ? $urandom : c.target_id;
            c.expected_rev = ($urandom_range(1)) ? $urandom : $urandom_range(2);
        end
        if ($urandom_range(19) == 0) c.now_ms = c.now_ms - 48'($urandom_range(100000));
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= !stall_free && ($urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t unexpected response %h", $time, out_data);
            end
            else
            begin
                cdt_pkg::rsp_t e;
                e = pending_rsp.pop_front();
                if (out_data !== e)
                begin
                    errors++;
                    $display("%0t mismatch expected %h actual %h", $time, e, out_data);
                    if (out_data.status !== e.status)
                        $display("  status expected %0d actual %0d", e.status, out_data.status);
                    if (out_data.view_remaining !== e.view_remaining)
                        $display("  remaining expected %0d actual %0d",
                                 e.view_remaining, out_data.view_remaining);
                    if (out_data.table_revision !== e.table_revision)
                        $display("  table_revision expected %0d actual %0d",
                                 e.table_revision, out_data.table_revision);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count > WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        cdt_pkg::rsp_t z;
        cdt_pkg::rsp_t r;
        cdt_pkg::cmd_t c;
        for (int i = 0; i < SLOTS; i++) clear_entry(i);
        m_table_rev = 1; m_next_id = 1; m_next_occ = 1;
        m_min_dur = cdt_pkg::MIN_DURATION_RST; m_max_dur = cdt_pkg::MAX_DURATION_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        z.table_revision = 1;
        add_row(mk(cdt_pkg::OP_TICK, 48'd0, 0, 0, 0), 1'b1, z);
        r = z; r.status = cdt_pkg::RC_INVALID;
        add_row(mk(cdt_pkg::opcode_t'(3'd6), TMASK, '1, '1, '1), 1'b1, r);
        add_row(mk(cdt_pkg::opcode_t'(3'd7), 48'd0, 0, 0, 0), 1'b1, r);
        add_row(mk(cdt_pkg::OP_CREATE, 48'd100, 999, 0, 0), 1'b1, r);
        add_row(mk(cdt_pkg::OP_CREATE, 48'd100, 86400001, 0, 0), 1'b1, r);
        add_row(mk(cdt_pkg::OP_PAUSE, 48'd100, 0, 1, 0), 1'b1, r);
        r = z; r.status = cdt_pkg::RC_CAPACITY;
        add_row(mk(cdt_pkg::OP_CREATE, TMASK - 500, 1000, 0, 0), 1'b1, r);
        r = z; r.status = cdt_pkg::RC_ABSENT;
        add_row(mk(cdt_pkg::OP_CANCEL, 48'd100, 0, 0, 1), 1'b1, r);
        add_row(mk(cdt_pkg::OP_CREATE, 48'd1000, 1000, 0, 0), 1'b0, z);
        add_row(mk(cdt_pkg::OP_CREATE, 48'd1000, 86400000, 0, 0), 1'b0, z);
        add_row(mk(cdt_pkg::OP_PAUSE, 48'd1500, 0, 1, 2), 1'b0, z);
        add_row(mk(cdt_pkg::OP_PAUSE, 48'd1500, 0, 1, 1), 1'b0, z);
        add_row(mk(cdt_pkg::OP_RESUME, 48'd100, 0, 1, 2), 1'b0, z);
        add_row(mk(cdt_pkg::OP_PAUSE, 48'd0, 0, 2, 1), 1'b0, z);
        add_row(mk(cdt_pkg::OP_RESUME, TMASK - 10, 0, 2, 2), 1'b0, z);
        add_row(mk(cdt_pkg::OP_TICK, 48'd5000000, 0, 0, 0), 1'b0, z);
        add_row(mk(cdt_pkg::OP_RESTART, 48'd6000000, 0, 1, 3), 1'b0, z);
        add_row(mk(cdt_pkg::OP_CANCEL, 48'd6000000, 0, 1, 4), 1'b0, z);
        for (int i = 0; i < SLOTS; i++)
            add_row(mk(cdt_pkg::OP_CREATE, 48'd7000000, 5000, 0, 0), 1'b0, z);
        foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].check, directed[i].rsp);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(cdt_pkg::CFG_MIN_DURATION, 32'd1);
                    write_reg(cdt_pkg::CFG_MAX_DURATION, '1);
                end
                1:
                begin
                    write_reg(cdt_pkg::CFG_MIN_DURATION, 32'd500);
                    write_reg(cdt_pkg::CFG_MAX_DURATION, 32'd8000);
                end
                2:
                begin
                    write_reg(cdt_pkg::CFG_MIN_DURATION, 32'd9000);
                    write_reg(cdt_pkg::CFG_MAX_DURATION, 32'd100);
                end
                default:
                begin
                    write_reg(cdt_pkg::CFG_MIN_DURATION, '1);
                    write_reg(cdt_pkg::CFG_MAX_DURATION, '1);
                end
            endcase
            if (phase == 1)
            begin
                c = mk(cdt_pkg::OP_CREATE, 48'd0, 32'd1, 0, 0);
                c.opcode = 3'b111; c.now_ms = TMASK; c.duration_in = '1;
                c.target_id = '1; c.expected_rev = '1;
                send_cmd(c, 1'b0, z);
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    repeat (6) send_cmd(random_cmd(), 1'b0, z);
                join
            end
            stall_free = (phase == 2);
            for (int n = 0; n < NUM_RANDOM / 4; n++) send_cmd(random_cmd(), 1'b0, z);
            stall_free = 1'b0;
            drain();
        end

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

### countdown_timer_table.f
src/cdt_pkg.sv
src/countdown_timer_table.sv
src/cdt_checker.sv
tb/sv/testbench.sv
